// ===== hw/rtl/npcq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette color quantizer package
// Field widths, command codes and default sizes that the block and its
// channel interfaces share.
// ----------------------------------------------------------------------------
package npcq_pkg;

    localparam int NPCQ_ENTRIES = 128;
    localparam int CHAN_W       = 8;
    localparam int INDEX_W      = 7;
    localparam int DIST_W       = 18;
    localparam int NUM_CHAN     = 4;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_PIXEL = 1'b1;

    localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;
    localparam logic [DIST_W-1:0] DIST_MAX     = 18'd260100;

    typedef logic [CHAN_W-1:0] chan_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [DIST_W-1:0] dist_t;

endpackage

// ===== hw/rtl/npcq_pixel_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pixel and palette write channel
// Valid/ready channel that carries one palette write or one pixel per item.
// ----------------------------------------------------------------------------
interface npcq_pixel_if
    import npcq_pkg::*;
();

    logic   valid;
    logic   ready;
    logic   command;
    index_t entry_index;
    chan_t  red;
    chan_t  green;
    chan_t  blue;
    chan_t  alpha;

    modport source (
        output valid, command, entry_index, red, green, blue, alpha,
        input  ready
    );

    modport sink (
        input  valid, command, entry_index, red, green, blue, alpha,
        output ready
    );

endinterface

// ===== hw/rtl/npcq_result_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Quantizer result channel
// Valid/ready channel that carries the nearest palette index and its distance.
// ----------------------------------------------------------------------------
interface npcq_result_if
    import npcq_pkg::*;
();

    logic   valid;
    logic   ready;
    index_t nearest_index;
    dist_t  best_distance;

    modport source (
        output valid, nearest_index, best_distance,
        input  ready
    );

    modport sink (
        input  valid, nearest_index, best_distance,
        output ready
    );

endinterface

// ===== hw/rtl/nearest_palette_color_quantizer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Nearest palette color quantizer
// Finds the palette entry with the least squared RGBA distance to a pixel.
// ----------------------------------------------------------------------------
// Items arrive on the pix channel. A palette write item (command 0) stores
// its four channels at entry_index when it is accepted; an index at or beyond
// PALETTE_ENTRIES is dropped. A pixel item (command 1) starts a search that
// reads one palette entry per cycle from the palette memory and feeds it
// through a shared distance unit (difference, square, sum and compare); the
// result goes to the res channel when the last entry has been compared.
// pix.ready is low for the whole search and until the result is loaded, so
// a new pixel is not accepted until the previous result has been loaded.
// The result is held in an output register; palette writes are still taken
// while it waits. If the receiver stalls, a second search finishes and then
// waits until the first result has been taken.
// Reset clears the entry valid bits, so every entry reads as zero until it
// is written, and sets alpha_present to 1. When alpha_present is 0 the
// pixel alpha is taken as fully opaque.
// ----------------------------------------------------------------------------
module nearest_palette_color_quantizer_top
    import npcq_pkg::*;
#(
    parameter int PALETTE_ENTRIES = NPCQ_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_wdata,
    npcq_pixel_if.sink         pix,
    npcq_result_if.source      res
);

    localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(PALETTE_ENTRIES + 1);
    localparam int EXT_W = 9;
    localparam logic [CNT_W-1:0] ENTRIES_CNT = CNT_W'(PALETTE_ENTRIES);
    localparam logic [EXT_W-1:0] ENTRIES_EXT = EXT_W'(PALETTE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(PALETTE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_FINISH = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic             alpha_present_reg;
    logic [CNT_W-1:0] rd_cnt_reg;
    logic [CNT_W-1:0] rd_cnt_next;

    logic [NUM_CHAN*CHAN_W-1:0] mem [PALETTE_ENTRIES];
    logic [PALETTE_ENTRIES-1:0] entry_valid_reg;
    logic [NUM_CHAN*CHAN_W-1:0] rd_data_reg;

    chan_t            px_reg [NUM_CHAN];
    logic             s1_valid_reg;
    logic             s1_hit_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_valid_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    logic [15:0]      sq_reg [NUM_CHAN];
    logic [IDX_W-1:0] best_idx_reg;
    dist_t            best_dist_reg;

    logic             out_valid_reg;
    index_t           out_idx_reg;
    dist_t            out_dist_reg;

    logic             accept;
    logic             wr_en;
    logic [EXT_W-1:0] wr_ext;
    logic [IDX_W-1:0] rd_addr;
    logic             issue;
    logic             out_load;
    logic             last_cmp;
    logic             take_best;
    dist_t            cand_dist;
    chan_t            ent [NUM_CHAN];
    chan_t            diff [NUM_CHAN];
    logic [15:0]      sq_next [NUM_CHAN];
    logic [EXT_W-1:0] best_ext;

    assign pix.ready = (state_reg == ST_IDLE);
    assign accept    = pix.valid && pix.ready;
    assign wr_ext    = EXT_W'(pix.entry_index);
    assign wr_en     = accept && (pix.command == CMD_WRITE) && (wr_ext < ENTRIES_EXT);
    assign rd_addr   = rd_cnt_reg[IDX_W-1:0];
    assign issue     = (state_reg == ST_SCAN) && (rd_cnt_reg < ENTRIES_CNT);
    assign out_load  = (state_reg == ST_FINISH) && (!out_valid_reg || res.ready);
    assign last_cmp  = s2_valid_reg && (s2_idx_reg == LAST_IDX);
    assign best_ext  = EXT_W'(best_idx_reg);

    always_comb
    begin
        state_next  = state_reg;
        rd_cnt_next = rd_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (pix.command == CMD_PIXEL))
                begin
                    state_next  = ST_SCAN;
                    rd_cnt_next = '0;
                end
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_cnt_next = rd_cnt_reg + 1'b1;
                end
                if (last_cmp)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            rd_cnt_reg        <= '0;
            alpha_present_reg <= 1'b1;
            entry_valid_reg   <= '0;
            s1_valid_reg      <= 1'b0;
            s2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_cnt_reg   <= rd_cnt_next;
            s1_valid_reg <= issue;
            s2_valid_reg <= s1_valid_reg;
            if (cfg_we)
            begin
                alpha_present_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                entry_valid_reg[wr_ext[IDX_W-1:0]] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ext[IDX_W-1:0]] <= {pix.red, pix.green, pix.blue, pix.alpha};
        end
        if (issue)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            ent[k] = s1_hit_reg ? rd_data_reg[(NUM_CHAN-1-k)*CHAN_W +: CHAN_W] : '0;
            diff[k] = (ent[k] > px_reg[k]) ? (ent[k] - px_reg[k]) : (px_reg[k] - ent[k]);
            sq_next[k] = 16'(diff[k]) * 16'(diff[k]);
        end
        cand_dist = DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1])
                  + DIST_W'(sq_reg[2]) + DIST_W'(sq_reg[3]);
        take_best = s2_valid_reg && ((s2_idx_reg == '0) || (cand_dist < best_dist_reg));
    end

    always_ff @(posedge clk)
    begin
        if (accept && (pix.command == CMD_PIXEL))
        begin
            px_reg[0] <= pix.red;
            px_reg[1] <= pix.green;
            px_reg[2] <= pix.blue;
            px_reg[3] <= alpha_present_reg ? pix.alpha : ALPHA_OPAQUE;
        end
        if (issue)
        begin
            s1_idx_reg <= rd_addr;
            s1_hit_reg <= entry_valid_reg[rd_addr];
        end
        if (s1_valid_reg)
        begin
            s2_idx_reg <= s1_idx_reg;
            for (int k = 0; k < NUM_CHAN; k++)
            begin
                sq_reg[k] <= sq_next[k];
            end
        end
        if (take_best)
        begin
            best_idx_reg  <= s2_idx_reg;
            best_dist_reg <= cand_dist;
        end
        if (out_load)
        begin
            out_idx_reg  <= best_ext[INDEX_W-1:0];
            out_dist_reg <= best_dist_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.nearest_index = out_idx_reg;
    assign res.best_distance = out_dist_reg;

    a_dist_range: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> (res.best_distance <= DIST_MAX))
        else $error("Result distance exceeds the largest possible RGBA distance.");

    a_busy_after_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (pix.command == CMD_PIXEL)) |=> !pix.ready)
        else $error("Block accepted an item right after a pixel item.");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_FINISH))
        else $error("Result appeared without a finished search.");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FINISH) |-> (best_ext < ENTRIES_EXT))
        else $error("Chosen palette index is beyond the palette.");

endmodule
